FILE: rtl/ntlg_pkg.sv
// Shared types and constants of the NTSC text line generator.
// No dependencies; the interfaces and the top level import this package.
package ntlg_pkg;

  localparam int ACTION_W = 2;
  localparam int ADDR_W   = 10;
  localparam int DATA_W   = 8;
  localparam int LINE_W   = 9;
  localparam int WORD_W   = 16;
  localparam int EDGE_W   = 11;
  localparam int TUNE_W   = 4;

  typedef logic [LINE_W-1:0] line_t;
  typedef logic [EDGE_W-1:0] edge_t;
  typedef logic signed [TUNE_W-1:0] tune_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_TEXT  = 2'd1,
    ACT_GLYPH = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TOUT,
    ST_RA,
    ST_RB,
    ST_GB,
    ST_PUT,
    ST_BLANK
  } state_t;

  localparam line_t SYNC_LINE_FIRST  = 9'd0;
  localparam line_t SYNC_LINE_SERR   = 9'd3;
  localparam line_t SYNC_LINE_EQ     = 9'd6;
  localparam line_t SYNC_LINE_NORMAL = 9'd9;
  localparam line_t FIRST_ACTIVE     = 9'd45;
  localparam line_t LAST_ACTIVE      = 9'd236;

  localparam edge_t PULSE_NORMAL = 11'd54;
  localparam edge_t PULSE_SERR   = 11'd648;
  localparam edge_t PULSE_POST   = 11'd112;
  localparam edge_t EDGE_SECOND  = 11'd1410;
  localparam edge_t EDGE_EVENT   = 11'd1411;
  localparam edge_t EDGE_EQ      = 11'd816;
  localparam edge_t EVENT_POST   = 11'd192;

  localparam int ROW_STRIDE     = 96;
  localparam int CHARS_PER_ROW  = 32;
  localparam int WORDS_PER_LINE = 16;

endpackage

FILE: rtl/ntlg_if.sv
// Valid/ready channel interfaces for input actions and result beats.
// Depends on ntlg_pkg for the field widths.
interface ntlg_in_if;
  import ntlg_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ADDR_W-1:0]   address;
  logic [DATA_W-1:0]   data;
  modport source (output valid, action, address, data, input ready);
  modport sink (input valid, action, address, data, output ready);
endinterface

interface ntlg_out_if;
  import ntlg_pkg::*;
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] line_number;
  logic              pixel_valid;
  logic [WORD_W-1:0] pixel_word;
  logic              last;
  logic [EDGE_W-1:0] pulse_end;
  logic [EDGE_W-1:0] second_edge;
  logic [EDGE_W-1:0] line_event;
  modport source (output valid, line_number, pixel_valid, pixel_word, last,
                  pulse_end, second_edge, line_event, input ready);
  modport sink (input valid, line_number, pixel_valid, pixel_word, last,
                pulse_end, second_edge, line_event, output ready);
endinterface

FILE: rtl/ntsc_text_line_generator_unit.sv
// Top level of the NTSC text line generator: text and glyph memories and the line sequencer.
// Depends on ntlg_pkg and the channel interfaces in ntlg_if.sv.
// Write actions complete in ST_IDLE. A blank line tick goes to ST_TOUT, which loads its single
// beat once the output is free. An active line tick steps through ST_RA, ST_RB and ST_GB to
// ST_PUT, then alternates ST_GB and ST_PUT per word, holding in ST_PUT while the output is
// full, and gives the blank word last from ST_BLANK; the alternation is set by the single read
// port of each memory. After reset the text memory is cleared before any input is accepted.
module ntsc_text_line_generator_unit #(
  parameter int TEXT_CELLS      = 768,
  parameter int GLYPH_DEPTH     = 1024,
  parameter int LINES_PER_FRAME = 262
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  ntlg_pkg::tune_t cfg_wdata,
  ntlg_in_if.sink         in_bus,
  ntlg_out_if.source      out_bus
);
  import ntlg_pkg::*;

  localparam int TA_W = $clog2(TEXT_CELLS);
  localparam int GA_W = $clog2(GLYPH_DEPTH);
  localparam logic [TA_W:0] TC_L = (TA_W+1)'(TEXT_CELLS);
  localparam logic [TA_W-1:0] TC_LAST = TA_W'(TEXT_CELLS - 1);
  localparam line_t LINE_LAST = line_t'(LINES_PER_FRAME - 1);

  logic [DATA_W-1:0] text_ram [TEXT_CELLS];
  logic [DATA_W-1:0] glyph_ram [GLYPH_DEPTH];

  state_t state_r, state_nxt;
  logic [TA_W-1:0] clr_cnt_r;
  line_t line_cnt_r, cur_line_r;
  tune_t tune_r;
  edge_t pulse_end_r, second_edge_r, line_event_r;
  logic [TA_W-1:0] lbase_r, tptr_r;
  logic [ADDR_W-1:0] rowoff_r;
  logic [3:0] word_cnt_r;
  logic [DATA_W-1:0] text_q_r, glyph_q_r, hold_a_r;

  logic out_valid_r;
  line_t out_line_r;
  logic out_pix_r, out_last_r;
  logic [WORD_W-1:0] out_word_r;
  edge_t out_pe_r, out_se_r, out_le_r;

  logic in_acc, out_free, is_active, tick_acc;
  logic t_we, t_re, g_we, g_re, out_load, ptr_step, hold_load, word_step;
  logic [TA_W-1:0] t_wa;
  logic [DATA_W-1:0] t_wd;
  logic [GA_W-1:0] g_ra;
  logic out_pix_nxt, out_last_nxt;
  logic [WORD_W-1:0] out_word_nxt;
  logic [TA_W:0] ptr_sum, base_sum, start_base;
  logic [TA_W-1:0] ptr_nxt, lbase_nxt;
  logic [7:0] vrow;
  edge_t tune_x2, tune_x4;

  assign in_acc   = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;
  assign in_bus.ready = (state_r == ST_IDLE);
  assign tick_acc = in_acc && (in_bus.action == ACT_TICK);
  assign is_active = (line_cnt_r >= FIRST_ACTIVE) && (line_cnt_r <= LAST_ACTIVE);
  assign vrow = 8'(line_cnt_r - FIRST_ACTIVE);

  assign ptr_sum = {1'b0, tptr_r} + (TA_W+1)'(1);
  assign ptr_nxt = (ptr_sum >= TC_L) ? TA_W'(ptr_sum - TC_L) : ptr_sum[TA_W-1:0];
  assign start_base = (line_cnt_r == FIRST_ACTIVE) ? '0 : {1'b0, lbase_r};
  assign base_sum = start_base + (TA_W+1)'(CHARS_PER_ROW);
  assign lbase_nxt = (base_sum >= TC_L) ? TA_W'(base_sum - TC_L) : base_sum[TA_W-1:0];

  assign tune_x2 = edge_t'({{(EDGE_W-TUNE_W){tune_r[TUNE_W-1]}}, tune_r}) << 1;
  assign tune_x4 = edge_t'({{(EDGE_W-TUNE_W){tune_r[TUNE_W-1]}}, tune_r}) << 2;

  assign g_ra = GA_W'(rowoff_r + {{(ADDR_W-DATA_W){1'b0}}, text_q_r});

  always_comb begin
    state_nxt    = state_r;
    t_we         = 1'b0;
    t_wa         = TA_W'(in_bus.address);
    t_wd         = in_bus.data;
    t_re         = 1'b0;
    g_we         = 1'b0;
    g_re         = 1'b0;
    ptr_step     = 1'b0;
    hold_load    = 1'b0;
    word_step    = 1'b0;
    out_load     = 1'b0;
    out_pix_nxt  = 1'b0;
    out_last_nxt = 1'b0;
    out_word_nxt = '0;
    unique case (state_r)
      ST_CLEAR: begin
        t_we = 1'b1;
        t_wa = clr_cnt_r;
        t_wd = '0;
        if (clr_cnt_r == TC_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_bus.action)
            ACT_TICK: state_nxt = is_active ? ST_RA : ST_TOUT;
            ACT_TEXT: t_we = (13'(in_bus.address) < 13'(TEXT_CELLS));
            ACT_GLYPH: g_we = (13'(in_bus.address) < 13'(GLYPH_DEPTH));
            default: ;
          endcase
        end
      end
      ST_TOUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_RA: begin
        t_re      = 1'b1;
        ptr_step  = 1'b1;
        state_nxt = ST_RB;
      end
      ST_RB: begin
        t_re      = 1'b1;
        g_re      = 1'b1;
        ptr_step  = 1'b1;
        state_nxt = ST_GB;
      end
      ST_GB: begin
        g_re      = 1'b1;
        hold_load = 1'b1;
        if (word_cnt_r != 4'(WORDS_PER_LINE - 1)) begin
          t_re     = 1'b1;
          ptr_step = 1'b1;
        end
        state_nxt = ST_PUT;
      end
      ST_PUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_pix_nxt  = 1'b1;
          out_word_nxt = {hold_a_r, glyph_q_r};
          if (word_cnt_r == 4'(WORDS_PER_LINE - 1)) begin
            state_nxt = ST_BLANK;
          end else begin
            word_step = 1'b1;
            t_re      = 1'b1;
            g_re      = 1'b1;
            ptr_step  = 1'b1;
            state_nxt = ST_GB;
          end
        end
      end
      ST_BLANK: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_pix_nxt  = 1'b1;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      text_ram[t_wa] <= t_wd;
    end
    if (t_re) begin
      text_q_r <= text_ram[tptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      glyph_ram[GA_W'(in_bus.address)] <= in_bus.data;
    end
    if (g_re) begin
      glyph_q_r <= glyph_ram[g_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r     <= '0;
      line_cnt_r    <= '0;
      tune_r        <= '0;
      pulse_end_r   <= PULSE_NORMAL;
      second_edge_r <= EDGE_SECOND;
      line_event_r  <= EDGE_EVENT;
      lbase_r       <= '0;
      word_cnt_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + TA_W'(1);
      end
      if (cfg_we) begin
        tune_r <= cfg_wdata;
      end
      if (tick_acc) begin
        line_cnt_r <= (line_cnt_r >= LINE_LAST) ? '0 : line_cnt_r + 9'd1;
        unique case (line_cnt_r)
          SYNC_LINE_FIRST: begin
            pulse_end_r  <= PULSE_NORMAL;
            line_event_r <= EDGE_EVENT + tune_x4;
          end
          SYNC_LINE_SERR: begin
            pulse_end_r   <= PULSE_SERR + tune_x2;
            second_edge_r <= EDGE_SECOND + tune_x4;
          end
          SYNC_LINE_EQ: begin
            pulse_end_r   <= PULSE_NORMAL;
            second_edge_r <= EDGE_EQ + tune_x2;
          end
          SYNC_LINE_NORMAL: begin
            pulse_end_r  <= PULSE_POST;
            line_event_r <= EVENT_POST;
          end
          default: ;
        endcase
        if (is_active) begin
          word_cnt_r <= '0;
          if (vrow[2:0] == 3'd7) begin
            lbase_r <= lbase_nxt;
          end else begin
            lbase_r <= start_base[TA_W-1:0];
          end
        end
      end
      if (word_step) begin
        word_cnt_r <= word_cnt_r + 4'd1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      cur_line_r <= line_cnt_r;
      tptr_r     <= start_base[TA_W-1:0];
      rowoff_r   <= ADDR_W'(vrow[2:0]) * ADDR_W'(ROW_STRIDE);
    end else if (ptr_step) begin
      tptr_r <= ptr_nxt;
    end
    if (hold_load) begin
      hold_a_r <= glyph_q_r;
    end
    if (out_load) begin
      out_line_r <= cur_line_r;
      out_pix_r  <= out_pix_nxt;
      out_last_r <= out_last_nxt;
      out_word_r <= out_word_nxt;
      out_pe_r   <= pulse_end_r;
      out_se_r   <= second_edge_r;
      out_le_r   <= line_event_r;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.line_number = out_line_r;
  assign out_bus.pixel_valid = out_pix_r;
  assign out_bus.pixel_word  = out_word_r;
  assign out_bus.last        = out_last_r;
  assign out_bus.pulse_end   = out_pe_r;
  assign out_bus.second_edge = out_se_r;
  assign out_bus.line_event  = out_le_r;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_bus.ready)
    else $error("input accepted during text memory clear");

  a_blank_beat_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pix_r) |-> (out_last_r && (out_word_r == '0)))
    else $error("timing-only beat is not a final empty beat");

  a_inactive_no_video: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_line_r < FIRST_ACTIVE) || (out_line_r > LAST_ACTIVE)))
      |-> !out_pix_r)
    else $error("video beat on an inactive line");

  a_line_advance: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> (line_cnt_r == (($past(line_cnt_r) == LINE_LAST) ? 9'd0
                                  : 9'($past(line_cnt_r) + 9'd1))))
    else $error("line counter did not advance on a line tick");

endmodule

FILE: tb/ntsc_text_line_generator_unit_tb.sv
// Self-checking testbench for the NTSC text line generator top level.
// Predicts every result beat from its own model of the line counter, the stores
// and the sync edges; depends on ntlg_pkg, ntlg_if.sv and the top level RTL.
module ntsc_text_line_generator_unit_tb;
  import ntlg_pkg::*;

  localparam int TEXT_CELLS      = 768;
  localparam int GLYPH_DEPTH     = 1024;
  localparam int LINES_PER_FRAME = 262;
  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int MAX_REPORTS     = 60;
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    line_t             line_number;
    logic              pixel_valid;
    logic [WORD_W-1:0] pixel_word;
    logic              last;
    edge_t             pulse_end;
    edge_t             second_edge;
    edge_t             line_event;
  } line_beat_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  tune_t cfg_wdata;

  ntlg_in_if  in_bus();
  ntlg_out_if out_bus();

  ntsc_text_line_generator_unit #(
    .TEXT_CELLS     (TEXT_CELLS),
    .GLYPH_DEPTH    (GLYPH_DEPTH),
    .LINES_PER_FRAME(LINES_PER_FRAME)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_bus   (in_bus),
    .out_bus  (out_bus)
  );

  line_t       line_ctr = '0;
  tune_t       tune_q = '0;
  edge_t       pulse_q = PULSE_NORMAL;
  edge_t       second_q = EDGE_SECOND;
  edge_t       event_q = EDGE_EVENT;
  logic [7:0]  text_mem [TEXT_CELLS] = '{default: 8'h00};
  logic [7:0]  glyph_mem [GLYPH_DEPTH] = '{default: 8'h00};
  bit          glyph_set [GLYPH_DEPTH] = '{default: 1'b0};
  line_beat_t  pending_beats[$];
  int          mismatches = 0;
  int          ticks_sent = 0;
  int          hold_left = 0;
  int          cycle_count = 0;
  bit          gaps_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic edge_t tuned(edge_t base, int mult);
    int sum;
    sum = int'(base) + int'(tune_q) * mult;
    return edge_t'(sum);
  endfunction

  // Glyph store index read for character slot 0..31 of the current line.
  function automatic int glyph_index(int slot);
    int v;
    v = int'(line_ctr) - int'(FIRST_ACTIVE);
    return (v & 7) * ROW_STRIDE + int'(text_mem[((v >> 3) * CHARS_PER_ROW + slot) % TEXT_CELLS]);
  endfunction

  function automatic logic [7:0] glyph_byte(int idx);
    return (idx < GLYPH_DEPTH) ? glyph_mem[idx] : 8'h00;
  endfunction

  function automatic void advance_line();
    line_beat_t b;
    int i;
    case (line_ctr)
      SYNC_LINE_FIRST: begin
        pulse_q = PULSE_NORMAL;
        event_q = tuned(EDGE_EVENT, 4);
      end
      SYNC_LINE_SERR: begin
        pulse_q  = tuned(PULSE_SERR, 2);
        second_q = tuned(EDGE_SECOND, 4);
      end
      SYNC_LINE_EQ: begin
        pulse_q  = PULSE_NORMAL;
        second_q = tuned(EDGE_EQ, 2);
      end
      SYNC_LINE_NORMAL: begin
        pulse_q = PULSE_POST;
        event_q = EVENT_POST;
      end
      default: ;
    endcase
    b.line_number = line_ctr;
    b.pulse_end   = pulse_q;
    b.second_edge = second_q;
    b.line_event  = event_q;
    b.pixel_word  = '0;
    b.last        = 1'b1;
    if (line_ctr >= FIRST_ACTIVE && line_ctr <= LAST_ACTIVE) begin
      b.pixel_valid = 1'b1;
      b.last        = 1'b0;
      for (i = 0; i < WORDS_PER_LINE; i++) begin
        b.pixel_word = {glyph_byte(glyph_index(2 * i)), glyph_byte(glyph_index(2 * i + 1))};
        pending_beats.push_back(b);
      end
      b.pixel_word = '0;
      b.last       = 1'b1;
    end else begin
      b.pixel_valid = 1'b0;
    end
    pending_beats.push_back(b);
    line_ctr = (int'(line_ctr) + 1 >= LINES_PER_FRAME) ? line_t'(0) : line_ctr + 1'b1;
  endfunction

  function automatic void model_item(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr,
                                     logic [DATA_W-1:0] data);
    case (act)
      ACT_TICK: advance_line();
      ACT_TEXT: if (addr < TEXT_CELLS) text_mem[addr] = data;
      ACT_GLYPH: begin
        if (addr < GLYPH_DEPTH) begin
          glyph_mem[addr] = data;
          glyph_set[addr] = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // Entered and left just after a falling edge.
  task automatic send_item(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr,
                           logic [DATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.action  <= act;
    in_bus.address <= addr;
    in_bus.data    <= data;
    forever begin
      @(posedge clk);
      if (in_bus.ready) break;
    end
    model_item(act, addr, data);
    @(negedge clk);
  endtask

  task automatic send_tick();
    int s;
    int idx;
    if (line_ctr >= FIRST_ACTIVE && line_ctr <= LAST_ACTIVE) begin
      for (s = 0; s < 2 * WORDS_PER_LINE; s++) begin
        idx = glyph_index(s);
        if (!glyph_set[idx]) send_item(ACT_GLYPH, ADDR_W'(idx), DATA_W'($urandom_range(0, 255)));
      end
    end
    send_item(ACT_TICK, ADDR_W'($urandom_range(0, 1023)), DATA_W'($urandom_range(0, 255)));
    ticks_sent++;
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_tune(tune_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    tune_q = value;
  endtask

  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 99) < 5) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      4: return 8'h41;
      5: return 8'h5A;
      6: return 8'h21;
      default: return 8'hC3;
    endcase
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  initial begin : result_check
    line_beat_t want;
    logic took;
    int sink_wait;
    sink_wait = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      took = rst_n && out_bus.valid && out_bus.ready;
      if (took) begin
        if (pending_beats.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: beat expected none, got line %0d word %0h", $time,
                     out_bus.line_number, out_bus.pixel_word);
          mismatches++;
        end else begin
          want = pending_beats.pop_front();
          check_field("line_number", 16'(want.line_number), 16'(out_bus.line_number));
          check_field("pixel_valid", 16'(want.pixel_valid), 16'(out_bus.pixel_valid));
          check_field("pixel_word", want.pixel_word, out_bus.pixel_word);
          check_field("last", 16'(want.last), 16'(out_bus.last));
          check_field("pulse_end", 16'(want.pulse_end), 16'(out_bus.pulse_end));
          check_field("second_edge", 16'(want.second_edge), 16'(out_bus.second_edge));
          check_field("line_event", 16'(want.line_event), 16'(out_bus.line_event));
        end
      end
      @(negedge clk);
      if (took) sink_wait = pick_gap();
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Lines 0 to 10 with a different trim before each group of edge updates.
  task automatic test_sync_edges();
    write_tune(tune_t'(-8));
    send_tick();
    drain();
    write_tune(tune_t'(7));
    repeat (3) send_tick();
    drain();
    write_tune(tune_t'(-4));
    repeat (3) send_tick();
    drain();
    write_tune(tune_t'(4));
    repeat (4) send_tick();
    drain();
  endtask

  task automatic test_store_writes();
    send_item(ACT_TEXT, 10'd0, 8'hFF);
    send_item(ACT_TEXT, 10'd767, 8'h80);
    send_item(ACT_TEXT, 10'd768, 8'h55);
    send_item(ACT_TEXT, 10'd1023, 8'hFF);
    send_item(ACT_GLYPH, 10'd1023, 8'hFF);
    send_item(ACT_GLYPH, 10'd0, 8'h00);
    send_item(ACT_NONE, 10'd1023, 8'hFF);
    send_item(ACT_NONE, 10'd0, 8'h00);
    drain();
  endtask

  task automatic test_random_traffic(int tick_goal);
    int unsigned r;
    while (ticks_sent < tick_goal) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        send_tick();
      end else if (r < 80) begin
        send_item(ACT_TEXT, ($urandom_range(0, 99) < 85) ? ADDR_W'($urandom_range(0, 767))
                                                         : ADDR_W'($urandom_range(768, 1023)),
                  pick_code());
      end else if (r < 90) begin
        send_item(ACT_GLYPH, ADDR_W'($urandom_range(0, 1023)), DATA_W'($urandom_range(0, 255)));
      end else if (r < 94) begin
        send_item(ACT_NONE, ADDR_W'($urandom_range(0, 1023)), DATA_W'($urandom_range(0, 255)));
      end else if (r < 97) begin
        drain();
        write_tune(tune_t'($urandom_range(0, 15)));
      end else begin
        gaps_on = !gaps_on;
      end
    end
    gaps_on = 1'b1;
    drain();
  endtask

  // The sink stops for a long stretch while ticks keep coming, so the block
  // has to hold off its input.
  task automatic test_output_stall();
    gaps_on = 1'b0;
    hold_left = 400;
    repeat (6) send_tick();
    gaps_on = 1'b1;
    drain();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_bus.valid   = 1'b0;
    in_bus.action  = '0;
    in_bus.address = '0;
    in_bus.data    = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_sync_edges();
    test_store_writes();
    test_random_traffic(160);
    test_output_stall();
    test_random_traffic(265);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: ntsc_text_line_generator_unit.f
rtl/ntlg_pkg.sv
rtl/ntlg_if.sv
rtl/ntsc_text_line_generator_unit.sv
tb/ntsc_text_line_generator_unit_tb.sv
